// ----- rtl/core/fpvn_pkg.sv -----
// ----------------------------------------------------------------------------
// fpvn_pkg: shared constants and types for the vector normalizer
// Fraction width, derived widths and the per-stage payload struct.
// ----------------------------------------------------------------------------
package fpvn_pkg;
    localparam int FRAC_BITS = 16;
    localparam int PART_W    = 32 - FRAC_BITS;      // signed integer part width
    localparam int SQ_W      = 2 * PART_W;           // unsigned square width
    localparam int SUM_W     = SQ_W + 2;             // sum of three squares
    localparam int ROOT_W    = SUM_W / 2;            // floor sqrt width
    localparam int SQ_STEPS  = ROOT_W;               // one root bit per stage
    localparam int RECIP_W   = 17;                   // 1 .. 65536
    localparam int DIV_STEPS = RECIP_W;              // one quotient bit per stage
    localparam int PROD_W    = 32 + RECIP_W + 1;     // signed product width

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               pass;   // all integer parts zero: return input
    } t_vec;
endpackage

// ----- rtl/core/fpvn_sqrt.sv -----
// ----------------------------------------------------------------------------
// fpvn_sqrt: squares, sums and pipelined floor square root
// One register stage for squares, one for the sum, one per root bit.
// ----------------------------------------------------------------------------
module fpvn_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  fpvn_pkg::t_vec                 i_vec,
    output logic                           o_valid,
    output fpvn_pkg::t_vec                 o_vec,
    output logic [fpvn_pkg::ROOT_W-1:0]    o_root
);
    import fpvn_pkg::*;

    // stage A: squares
    logic              r_va;
    t_vec              r_veca;
    logic [SQ_W-1:0]   r_sq [3];
    logic signed [PART_W-1:0] w_px, w_py, w_pz;
    logic signed [SQ_W-1:0]   w_wx, w_wy, w_wz;
    assign w_px = i_vec.x[31 -: PART_W];
    assign w_py = i_vec.y[31 -: PART_W];
    assign w_pz = i_vec.z[31 -: PART_W];
    assign w_wx = SQ_W'(w_px);
    assign w_wy = SQ_W'(w_py);
    assign w_wz = SQ_W'(w_pz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (i_en) r_va <= i_valid;
        if (i_en) begin
            r_veca  <= '{x: i_vec.x, y: i_vec.y, z: i_vec.z,
                         pass: (w_px == '0) && (w_py == '0) && (w_pz == '0)};
            r_sq[0] <= $unsigned(w_wx * w_wx);
            r_sq[1] <= $unsigned(w_wy * w_wy);
            r_sq[2] <= $unsigned(w_wz * w_wz);
        end
    end

    // stage B: sum
    logic             r_vb;
    t_vec             r_vecb;
    logic [SUM_W-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (i_en) r_vb <= r_va;
        if (i_en) begin
            r_vecb <= r_veca;
            r_sum  <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        end
    end

    // restoring root, one bit per stage, MSB first
    logic              r_v   [SQ_STEPS];
    t_vec              r_vs  [SQ_STEPS];
    logic [SUM_W-1:0]  r_rem [SQ_STEPS];
    logic [ROOT_W-1:0] r_rt  [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        localparam int B = SQ_STEPS - 1 - k;
        logic              w_vi;
        t_vec              w_vsi;
        logic [SUM_W-1:0]  w_remi;
        logic [ROOT_W-1:0] w_rti;
        logic [SUM_W+1:0]  w_trial;
        logic [SUM_W+1:0]  w_rem;
        if (k == 0) begin : g_first
            assign w_vi   = r_vb;
            assign w_vsi  = r_vecb;
            assign w_remi = r_sum;
            assign w_rti  = '0;
        end else begin : g_next
            assign w_vi   = r_v[k-1];
            assign w_vsi  = r_vs[k-1];
            assign w_remi = r_rem[k-1];
            assign w_rti  = r_rt[k-1];
        end
        assign w_trial = ((SUM_W+2)'(w_rti) << (B + 1)) | ((SUM_W+2)'(1) << (2 * B));
        assign w_rem   = (SUM_W+2)'(w_remi);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k] <= 1'b0;
            else if (i_en) r_v[k] <= w_vi;
            if (i_en) begin
                r_vs[k] <= w_vsi;
                if (w_rem >= w_trial) begin
                    r_rem[k] <= SUM_W'(w_rem - w_trial);
                    r_rt[k]  <= w_rti | (ROOT_W'(1) << B);
                end else begin
                    r_rem[k] <= w_remi;
                    r_rt[k]  <= w_rti;
                end
            end
        end
    end

    assign o_valid = r_v[SQ_STEPS-1];
    assign o_vec   = r_vs[SQ_STEPS-1];
    assign o_root  = r_rt[SQ_STEPS-1];
endmodule

// ----- rtl/core/fpvn_recip.sv -----
// ----------------------------------------------------------------------------
// fpvn_recip: pipelined reciprocal floor(65536 / root)
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fpvn_recip (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  fpvn_pkg::t_vec                 i_vec,
    input  logic [fpvn_pkg::ROOT_W-1:0]    i_root,
    output logic                           o_valid,
    output fpvn_pkg::t_vec                 o_vec,
    output logic [fpvn_pkg::RECIP_W-1:0]   o_recip
);
    import fpvn_pkg::*;

    localparam logic [RECIP_W-1:0] NUM = RECIP_W'(65536);

    logic               r_v   [DIV_STEPS];
    t_vec               r_vs  [DIV_STEPS];
    logic [ROOT_W-1:0]  r_den [DIV_STEPS];
    logic [ROOT_W:0]    r_rem [DIV_STEPS];
    logic [RECIP_W-1:0] r_q   [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int B = DIV_STEPS - 1 - k;
        logic               w_vi;
        t_vec               w_vsi;
        logic [ROOT_W-1:0]  w_deni;
        logic [ROOT_W:0]    w_remi;
        logic [RECIP_W-1:0] w_qi;
        logic [ROOT_W:0]    w_sh;
        if (k == 0) begin : g_first
            assign w_vi   = i_valid;
            assign w_vsi  = i_vec;
            assign w_deni = (i_root == '0) ? ROOT_W'(1) : i_root;
            assign w_remi = '0;
            assign w_qi   = '0;
        end else begin : g_next
            assign w_vi   = r_v[k-1];
            assign w_vsi  = r_vs[k-1];
            assign w_deni = r_den[k-1];
            assign w_remi = r_rem[k-1];
            assign w_qi   = r_q[k-1];
        end
        assign w_sh = {w_remi[ROOT_W-1:0], NUM[B]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[k] <= 1'b0;
            else if (i_en) r_v[k] <= w_vi;
            if (i_en) begin
                r_vs[k]  <= w_vsi;
                r_den[k] <= w_deni;
                if (w_sh >= {1'b0, w_deni}) begin
                    r_rem[k] <= w_sh - {1'b0, w_deni};
                    r_q[k]   <= w_qi | (RECIP_W'(1) << B);
                end else begin
                    r_rem[k] <= w_sh;
                    r_q[k]   <= w_qi;
                end
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_vec   = r_vs[DIV_STEPS-1];
    assign o_recip = r_q[DIV_STEPS-1];
endmodule

// ----- rtl/core/fixed_point_vector_normalizer_top.sv -----
// Throughput: one vector per cycle while no stall holds the pipeline; every stage is a register,
// root and divide resolve one bit per stage.
// A stall freezes the whole pipeline; ready is low only when the output is full
// and not being taken. Reset (synchronous, active low) clears all valid bits.
// ----------------------------------------------------------------------------
// fixed_point_vector_normalizer_top: streaming 3-vector normalizer
// Square root, reciprocal and scaling pipeline with a holding output register.
// ----------------------------------------------------------------------------
module fixed_point_vector_normalizer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_unit_x,
    output logic signed [31:0] o_unit_y,
    output logic signed [31:0] o_unit_z
);
    import fpvn_pkg::*;

    logic               w_en;
    t_vec               w_in;
    logic               w_sv, w_rv;
    t_vec               w_svec, w_rvec;
    logic [ROOT_W-1:0]  w_root;
    logic [RECIP_W-1:0] w_recip;

    // advance whenever the output slot is free or being drained
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        w_in.x    = i_vec_x;
        w_in.y    = i_vec_y;
        w_in.z    = i_vec_z;
        w_in.pass = 1'b0;
    end

    fpvn_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_valid), .i_vec(w_in),
        .o_valid(w_sv), .o_vec(w_svec), .o_root(w_root)
    );

    fpvn_recip u_recip (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_sv), .i_vec(w_svec), .i_root(w_root),
        .o_valid(w_rv), .o_vec(w_rvec), .o_recip(w_recip)
    );

    // scale stage: one 32x18 multiply per component
    logic                     r_mv;
    t_vec                     r_mvec;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] w_rs;
    logic signed [PROD_W-1:0] w_mx, w_my, w_mz;
    assign w_rs = {{(PROD_W-RECIP_W){1'b0}}, w_recip};
    assign w_mx = PROD_W'(w_rvec.x);
    assign w_my = PROD_W'(w_rvec.y);
    assign w_mz = PROD_W'(w_rvec.z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (w_en) r_mv <= w_rv;
        if (w_en) begin
            r_mvec    <= w_rvec;
            r_prod[0] <= w_mx * w_rs;
            r_prod[1] <= w_my * w_rs;
            r_prod[2] <= w_mz * w_rs;
        end
    end

    // output register
    logic               r_ov;
    logic signed [31:0] r_ux, r_uy, r_uz;
    logic signed [PROD_W-1:0] w_sx, w_sy, w_sz;
    assign w_sx = r_prod[0] >>> FRAC_BITS;
    assign w_sy = r_prod[1] >>> FRAC_BITS;
    assign w_sz = r_prod[2] >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r_mv;
        if (w_en) begin
            r_ux <= r_mvec.pass ? r_mvec.x : w_sx[31:0];
            r_uy <= r_mvec.pass ? r_mvec.y : w_sy[31:0];
            r_uz <= r_mvec.pass ? r_mvec.z : w_sz[31:0];
        end
    end

    assign o_valid  = r_ov;
    assign o_unit_x = r_ux;
    assign o_unit_y = r_uy;
    assign o_unit_z = r_uz;
endmodule

// ----- dv/fpvn_checker.sv -----
// ----------------------------------------------------------------------------
// fpvn_checker: scoreboard for the vector normalizer
// Watches both channels, computes the normalized vector for every accepted
// request and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module fpvn_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_unit_x,
    input  logic signed [31:0] i_unit_y,
    input  logic signed [31:0] i_unit_z,
    output int                 o_fail_count,
    output int                 o_pending
);
    import fpvn_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_unit;

    t_unit unit_queue[$];

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_unit normalize(input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z);
        logic signed [63:0] comp [3];
        logic signed [63:0] part [3];
        logic [63:0]        sum;
        logic [63:0]        root;
        logic signed [63:0] recip;
        logic signed [63:0] scaled [3];
        t_unit              res;
        comp[0] = x;
        comp[1] = y;
        comp[2] = z;
        sum = 0;
        for (int i = 0; i < 3; i++) part[i] = comp[i] >>> FRAC_BITS;
        if (part[0] == 0 && part[1] == 0 && part[2] == 0) begin
            res.x = x;
            res.y = y;
            res.z = z;
            return res;
        end
        for (int i = 0; i < 3; i++) sum = sum + 64'(part[i] * part[i]);
        root = floor_sqrt(sum);
        if (root == 0) root = 1;
        recip = 64'(65536 / root);
        for (int i = 0; i < 3; i++) scaled[i] = (comp[i] * recip) >>> FRAC_BITS;
        res.x = scaled[0][31:0];
        res.y = scaled[1][31:0];
        res.z = scaled[2][31:0];
        return res;
    endfunction

    assign o_pending = unit_queue.size();

    always @(posedge i_clk) begin
        t_unit want;
        if (!i_rst_n) begin
            unit_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                unit_queue.push_back(normalize(i_vec_x, i_vec_y, i_vec_z));
            if (i_out_valid && i_out_ready) begin
                if (unit_queue.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                             i_unit_x, i_unit_y, i_unit_z);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = unit_queue.pop_front();
                    if (want.x !== i_unit_x || want.y !== i_unit_y ||
                        want.z !== i_unit_z) begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h actual x=%h y=%h z=%h",
                                 $time, want.x, want.y, want.z,
                                 i_unit_x, i_unit_y, i_unit_z);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/fixed_point_vector_normalizer_top_test.sv -----
// ----------------------------------------------------------------------------
// fixed_point_vector_normalizer_top_test: stimulus and verdict
// Drives directed and random vectors with bursty requests and a stalling
// receiver, including one long hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module fixed_point_vector_normalizer_top_test;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_vec_x;
    logic signed [31:0] i_vec_y;
    logic signed [31:0] i_vec_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_unit_x;
    logic signed [31:0] o_unit_y;
    logic signed [31:0] o_unit_z;
    int                 fail_count;
    int                 pending;
    bit                 stim_done;

    fixed_point_vector_normalizer_top dut (.*);

    fpvn_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_vec_x(i_vec_x), .i_vec_y(i_vec_y), .i_vec_z(i_vec_z),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_unit_x(o_unit_x), .i_unit_y(o_unit_y), .i_unit_z(o_unit_z),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'hFFFF);
            2: return -$urandom_range(0, 32'h10000);
            3: return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'hFFF_FFFF) - 32'h800_0000;
        endcase
    endfunction

    // Present one request and hold it until accepted.
    task automatic send(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        i_valid <= 1;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    logic [31:0] directed [][3] = '{
        '{32'h0, 32'h0, 32'h0},
        '{32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_1234},
        '{32'hFFFF_FFFF, 32'h0, 32'h0},
        '{32'h0001_0000, 32'h0, 32'h0},
        '{32'h0, 32'hFFFF_0000, 32'h0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0},
        '{32'h0003_0000, 32'h0004_0000, 32'h0},
        '{32'h0001_8000, 32'hFFFE_8000, 32'h0000_8000},
        '{32'h8000_0000, 32'h0, 32'h0000_FFFF},
        '{32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
    };

    // Receiver stall pattern, with one long hold-off partway through.
    initial begin
        int n;
        i_ready = 0;
        @(posedge i_rst_n);
        n = 0;
        forever begin
            @(negedge i_clk);
            n++;
            if (n == 300) begin
                i_ready <= 0;
                repeat (200) @(negedge i_clk);
            end else if (n < 100 || (n > 1200 && n < 1400)) begin
                i_ready <= 1;
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        int burst;
        int gap;
        i_rst_n = 0;
        i_valid = 0;
        i_vec_x = 0;
        i_vec_y = 0;
        i_vec_z = 0;
        stim_done = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        foreach (directed[k]) send(directed[k][0], directed[k][1], directed[k][2]);
        for (int k = 0; k < 750;) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && k < 750; b++, k++)
                send(pick_comp(), pick_comp(), pick_comp());
            i_valid <= 0;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #500000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
